// File: design/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg
// types and constants shared by the resource pool modules
// ----------------------------------------------------------------------------
`default_nettype none
package brp_pkg;

   localparam logic [2:0] OP_BEGIN_FRAME = 3'd0;
   localparam logic [2:0] OP_ACQUIRE     = 3'd1;
   localparam logic [2:0] OP_END_FRAME   = 3'd2;
   localparam logic [2:0] OP_RECLAIM     = 3'd3;
   localparam logic [2:0] OP_HAS_ENTRY   = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_OVER       = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_PEND_FULL  = 2'd3;

   localparam logic CSR_BUDGET = 1'b0;
   localparam logic CSR_AGE    = 1'b1;

   localparam logic [63:0] FNV_BASIS = 64'h14650FB0739D0383;
   localparam logic [30:0] SIZE_SAT  = 31'h7FFFFFFF;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] name_tag;
      logic [14:0] tex_width;
      logic [14:0] tex_height;
      logic        pixel_format;
      logic [15:0] new_physical_id;
      logic [63:0] fence_value;
   } brp_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  entry_slot;
      logic        fresh;
      logic        found;
      logic        released_valid;
      logic [15:0] released_id;
      logic        last;
   } brp_rsp_type;

   typedef struct packed {
      logic load;
      logic hash_step;
      logic scan_step;
      logic finish;
   } brp_cmd_type;

   typedef struct packed {
      logic hash_last;
      logic scan_done;
      logic out_free;
   } brp_stat_type;

endpackage
`default_nettype wire

// File: design/budgeted_resource_pool.sv
// ----------------------------------------------------------------------------
// budgeted_resource_pool
// frame-aged texture pool with byte budget and fence-guarded release queue
// ----------------------------------------------------------------------------
// One item at a time. Acquire runs three hash rounds, then sweeps the slot
// table; end_frame and has_entry sweep the slot table; reclaim sweeps the
// pending queue and also waits for rsp_stall to drop, as each released id
// leaves through the single result register; begin_frame and unknown commands
// go straight to the finish phase. The sweep visits one entry per cycle,
// except while reclaim waits on a held released id. A new item is taken
// while the previous result still waits in the result register.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module budgeted_resource_pool #(
   parameter int POOL_ENTRIES    = 32,
   parameter int PENDING_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  brp_pkg::brp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output brp_pkg::brp_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [39:0]          csr_data
);
   import brp_pkg::*;

   brp_cmd_type  cmd;
   brp_stat_type stat;

   assign csr_ready = 1'b1;

   brp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   brp_datapath #(
      .POOL_ENTRIES    (POOL_ENTRIES),
      .PENDING_ENTRIES (PENDING_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: design/brp_ctrl.sv
// ----------------------------------------------------------------------------
// brp_ctrl
// sequencer: load, hash, sweep and finish phases of one item
// ----------------------------------------------------------------------------
`default_nettype none
module brp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_command,
   output logic                 req_stall,
   input  brp_pkg::brp_stat_type stat,
   output brp_pkg::brp_cmd_type  cmd
);
   import brp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_HASH   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_command == OP_ACQUIRE) begin
                  state_in = S_HASH;
               end else if (req_command inside {OP_END_FRAME, OP_RECLAIM, OP_HAS_ENTRY}) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (stat.hash_last) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// File: design/brp_datapath.sv
// ----------------------------------------------------------------------------
// brp_datapath
// slot table, pending queue, hash unit, sweep index and result register
// ----------------------------------------------------------------------------
`default_nettype none
module brp_datapath #(
   parameter int POOL_ENTRIES    = 32,
   parameter int PENDING_ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  brp_pkg::brp_req_type  req_data,
   input  logic                  csr_valid,
   input  logic                  csr_index,
   input  logic [39:0]           csr_data,
   input  brp_pkg::brp_cmd_type  cmd,
   output brp_pkg::brp_stat_type stat,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output brp_pkg::brp_rsp_type  rsp_data
);
   import brp_pkg::*;

   localparam int SW = $clog2(POOL_ENTRIES);
   localparam int PW = $clog2(PENDING_ENTRIES);
   localparam int CW = (SW > PW) ? SW : PW;
   localparam int NW = PW + 1;

   logic [39:0] budget_ff;
   logic [7:0]  age_ff;

   logic [POOL_ENTRIES-1:0] slot_valid_ff;
   logic [POOL_ENTRIES-1:0] slot_in_use_ff;
   logic [15:0] slot_name_ff [POOL_ENTRIES];
   logic [63:0] slot_hash_ff [POOL_ENTRIES];
   logic [30:0] slot_size_ff [POOL_ENTRIES];
   logic [15:0] slot_phys_ff [POOL_ENTRIES];
   logic [31:0] slot_last_ff [POOL_ENTRIES];

   logic [PENDING_ENTRIES-1:0] pend_valid_ff;
   logic [15:0] pend_phys_ff  [PENDING_ENTRIES];
   logic [30:0] pend_size_ff  [PENDING_ENTRIES];
   logic [63:0] pend_fence_ff [PENDING_ENTRIES];

   logic [NW-1:0] pend_count_ff;
   logic [31:0]   frame_ff;
   logic [39:0]   used_ff;

   brp_req_type req_ff;
   logic [63:0] hash_ff;
   logic [30:0] size_ff;
   logic [1:0]  hcnt_ff;
   logic [CW-1:0] idx_ff;
   logic        match_found_ff, free_found_ff, found_ff;
   logic [SW-1:0] match_idx_ff, free_idx_ff;
   logic [1:0]  st_ff;
   logic        held_valid_ff;
   logic [15:0] held_id_ff;
   logic [NW-1:0] n_ff, j_ff;
   logic        rsp_valid_ff;
   brp_rsp_type rsp_ff;

   logic [SW-1:0] sidx;
   logic [PW-1:0] pidx;
   logic        out_free, is_reclaim, at_last, rel, step_go, stale, over, emit;
   logic [31:0] age;
   logic [63:0] hash_x, hash_in;
   logic [29:0] area;
   logic [31:0] bytes4;
   logic [30:0] size_in;
   logic [40:0] used_sum;
   brp_rsp_type res;

   assign sidx       = idx_ff[SW-1:0];
   assign pidx       = idx_ff[PW-1:0];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign is_reclaim = (req_ff.command == OP_RECLAIM);
   assign at_last    = is_reclaim ? (idx_ff == CW'(PENDING_ENTRIES - 1))
                                  : (idx_ff == CW'(POOL_ENTRIES - 1));
   assign rel        = is_reclaim && pend_valid_ff[pidx]
                       && (pend_fence_ff[pidx] <= req_ff.fence_value);
   assign step_go    = cmd.scan_step && !(rel && held_valid_ff && !out_free);

   assign stat.hash_last = (hcnt_ff == 2'd2);
   assign stat.scan_done = step_go && at_last;
   assign stat.out_free  = out_free;

   assign age   = frame_ff - slot_last_ff[sidx];
   assign stale = slot_valid_ff[sidx] && !slot_in_use_ff[sidx] && (age > {24'd0, age_ff});

   // fnv-1a mix, prime is 2^40 + 0x1b3
   always_comb begin
      case (hcnt_ff)
         2'd0:    hash_x = hash_ff ^ {49'd0, req_ff.tex_width};
         2'd1:    hash_x = hash_ff ^ {49'd0, req_ff.tex_height};
         default: hash_x = hash_ff ^ {63'd0, req_ff.pixel_format};
      endcase
      hash_in = {hash_x[23:0], 40'd0} + (hash_x << 8) + (hash_x << 7) + (hash_x << 5)
                + (hash_x << 4) + (hash_x << 1) + hash_x;
   end

   assign area    = 30'(req_data.tex_width) * 30'(req_data.tex_height);
   assign bytes4  = {area, 2'b00};
   assign size_in = bytes4[31] ? SIZE_SAT : bytes4[30:0];

   assign used_sum = {1'b0, used_ff} + 41'(size_ff);
   assign over     = (budget_ff != 40'd0) && (used_sum > {1'b0, budget_ff});

   always_comb begin
      res      = '0;
      res.last = 1'b1;
      case (req_ff.command)
         OP_ACQUIRE: begin
            if (match_found_ff) begin
               res.entry_slot = 5'(match_idx_ff);
            end else if (over) begin
               res.status = ST_OVER;
            end else if (!free_found_ff) begin
               res.status = ST_TABLE_FULL;
            end else begin
               res.entry_slot = 5'(free_idx_ff);
               res.fresh      = 1'b1;
            end
         end
         OP_END_FRAME: res.status = st_ff;
         OP_RECLAIM: begin
            res.released_valid = held_valid_ff;
            res.released_id    = held_valid_ff ? held_id_ff : 16'd0;
         end
         OP_HAS_ENTRY: res.found = found_ff;
         default: res.last = 1'b1;
      endcase
      if (!cmd.finish) begin
         res                = '0;
         res.released_valid = 1'b1;
         res.released_id    = held_id_ff;
      end
   end

   assign emit = cmd.finish || (step_go && rel && held_valid_ff);

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff      <= '0;
         age_ff         <= 8'd3;
         slot_valid_ff  <= '0;
         slot_in_use_ff <= '0;
         pend_valid_ff  <= '0;
         pend_count_ff  <= '0;
         frame_ff       <= '0;
         used_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_BUDGET) begin
               budget_ff <= csr_data;
            end else begin
               age_ff <= csr_data[7:0];
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (step_go) begin
            if (req_ff.command == OP_END_FRAME && stale && n_ff < NW'(PENDING_ENTRIES)) begin
               pend_valid_ff[n_ff[PW-1:0]] <= 1'b1;
               slot_valid_ff[sidx]         <= 1'b0;
            end
            if (is_reclaim && pend_valid_ff[pidx]) begin
               if (rel) begin
                  pend_valid_ff[pidx] <= 1'b0;
                  used_ff <= (used_ff >= 40'(pend_size_ff[pidx]))
                             ? used_ff - 40'(pend_size_ff[pidx]) : 40'd0;
               end else if (j_ff[PW-1:0] != pidx) begin
                  pend_valid_ff[j_ff[PW-1:0]] <= 1'b1;
                  pend_valid_ff[pidx]         <= 1'b0;
               end
            end
         end
         if (cmd.finish) begin
            case (req_ff.command)
               OP_BEGIN_FRAME: begin
                  frame_ff       <= frame_ff + 32'd1;
                  slot_in_use_ff <= '0;
               end
               OP_ACQUIRE: begin
                  if (match_found_ff) begin
                     slot_in_use_ff[match_idx_ff] <= 1'b1;
                  end else if (!over && free_found_ff) begin
                     slot_valid_ff[free_idx_ff]  <= 1'b1;
                     slot_in_use_ff[free_idx_ff] <= 1'b1;
                     used_ff                     <= used_sum[39:0];
                  end
               end
               OP_END_FRAME: pend_count_ff <= n_ff;
               OP_RECLAIM:   pend_count_ff <= j_ff;
               default:      pend_count_ff <= pend_count_ff;
            endcase
         end
      end
   end

   // payload: item registers, sweep bookkeeping and stores
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff         <= req_data;
         hash_ff        <= FNV_BASIS;
         size_ff        <= size_in;
         hcnt_ff        <= 2'd0;
         idx_ff         <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         match_idx_ff   <= '0;
         free_idx_ff    <= '0;
         found_ff       <= 1'b0;
         st_ff          <= ST_OK;
         held_valid_ff  <= 1'b0;
         held_id_ff     <= '0;
         n_ff           <= pend_count_ff;
         j_ff           <= '0;
      end
      if (cmd.hash_step) begin
         hash_ff <= hash_in;
         hcnt_ff <= hcnt_ff + 2'd1;
      end
      if (step_go) begin
         idx_ff <= idx_ff + CW'(1);
         case (req_ff.command)
            OP_ACQUIRE: begin
               if (!match_found_ff && slot_valid_ff[sidx] && !slot_in_use_ff[sidx]
                   && slot_name_ff[sidx] == req_ff.name_tag && slot_hash_ff[sidx] == hash_ff) begin
                  match_found_ff <= 1'b1;
                  match_idx_ff   <= sidx;
               end
               if (!free_found_ff && !slot_valid_ff[sidx]) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= sidx;
               end
            end
            OP_END_FRAME: begin
               if (stale) begin
                  if (n_ff < NW'(PENDING_ENTRIES)) begin
                     pend_phys_ff[n_ff[PW-1:0]]  <= slot_phys_ff[sidx];
                     pend_size_ff[n_ff[PW-1:0]]  <= slot_size_ff[sidx];
                     pend_fence_ff[n_ff[PW-1:0]] <= req_ff.fence_value;
                     n_ff <= n_ff + NW'(1);
                  end else begin
                     st_ff <= ST_PEND_FULL;
                  end
               end
            end
            OP_RECLAIM: begin
               if (pend_valid_ff[pidx]) begin
                  if (rel) begin
                     held_valid_ff <= 1'b1;
                     held_id_ff    <= pend_phys_ff[pidx];
                  end else begin
                     pend_phys_ff[j_ff[PW-1:0]]  <= pend_phys_ff[pidx];
                     pend_size_ff[j_ff[PW-1:0]]  <= pend_size_ff[pidx];
                     pend_fence_ff[j_ff[PW-1:0]] <= pend_fence_ff[pidx];
                     j_ff <= j_ff + NW'(1);
                  end
               end
            end
            OP_HAS_ENTRY: begin
               if (slot_valid_ff[sidx] && slot_name_ff[sidx] == req_ff.name_tag) begin
                  found_ff <= 1'b1;
               end
            end
            default: found_ff <= found_ff;
         endcase
      end
      if (cmd.finish && req_ff.command == OP_ACQUIRE) begin
         if (match_found_ff) begin
            slot_last_ff[match_idx_ff] <= frame_ff;
         end else if (!over && free_found_ff) begin
            slot_name_ff[free_idx_ff] <= req_ff.name_tag;
            slot_hash_ff[free_idx_ff] <= hash_ff;
            slot_size_ff[free_idx_ff] <= size_ff;
            slot_phys_ff[free_idx_ff] <= req_ff.new_physical_id;
            slot_last_ff[free_idx_ff] <= frame_ff;
         end
      end
      if (emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
